@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/atrlc_pkg.sv @@
// Package with constants, codes, types and helpers of the AT response line classifier.
package atrlc_pkg;

   localparam int LINE_CAPACITY = 64;
   localparam int ADDR_W        = $clog2(LINE_CAPACITY);
   localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
   localparam int WORD_W        = 5;
   localparam int WIN_IDX_W     = $clog2(WORD_W);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_K     = 8'h4B;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_R     = 8'h52;

   localparam logic [2:0] KIND_OK    = 3'd0;
   localparam logic [2:0] KIND_ERROR = 3'd1;
   localparam logic [2:0] KIND_ECHO  = 3'd2;
   localparam logic [2:0] KIND_PLUS  = 3'd3;
   localparam logic [2:0] KIND_INFO  = 3'd4;

   localparam logic [1:0] SEC_TEXT    = 2'd0;
   localparam logic [1:0] SEC_NAME    = 2'd1;
   localparam logic [1:0] SEC_PAYLOAD = 2'd2;

   typedef struct packed {
      logic             clear;
      logic             vld;
      logic [LEN_W-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic             blank;
      logic [2:0]       kind;
      logic             two;
      logic             f_empty;
      logic [LEN_W-1:0] f_start;
      logic [LEN_W-1:0] f_end;
      logic             s_empty;
      logic [LEN_W-1:0] s_start;
      logic [LEN_W-1:0] s_end;
   } plan_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_term(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

@@ hw/rtl/atrlc_if.sv @@
// Valid/ready channel interfaces for the request bytes and the response items.
interface atrlc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface atrlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] line_kind;
   logic [1:0] section;
   logic       has_char;
   logic [7:0] char_value;
   logic       last_of_section;
   logic       last_of_line;

   modport source (output valid, output line_kind, output section, output has_char,
                   output char_value, output last_of_section, output last_of_line,
                   input ready);
   modport sink (input valid, input line_kind, input section, input has_char,
                 input char_value, input last_of_section, input last_of_line,
                 output ready);
endinterface

@@ hw/rtl/atrlc_line_ram.sv @@
// Line store: one write port and one registered read port.
module atrlc_line_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [atrlc_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic                        rd_en,
   input  logic [atrlc_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem_ff [atrlc_pkg::LINE_CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/atrlc_scan.sv @@
// Line scanner: tracks trim bounds, colon split and leading word, and derives the output plan.
module atrlc_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  atrlc_pkg::scan_ctl_type  ctl,
   input  logic [7:0]               rd_data,
   output atrlc_pkg::plan_type      plan
);

   logic                        s_found_ff, a_found_ff, colon_found_ff, name_any_ff, ps_found_ff;
   logic [atrlc_pkg::LEN_W-1:0] s_ff, e_ff, a_ff, ne_ff, ps_ff;
   logic [7:0]                  win_ff [atrlc_pkg::WORD_W];
   logic [atrlc_pkg::LEN_W-1:0] diff;
   logic [atrlc_pkg::LEN_W-1:0] len;
   logic                        nb;
   logic                        is_ok, is_err, is_echo, is_plus;

   assign nb   = !atrlc_pkg::is_blank(rd_data);
   assign diff = ctl.idx - s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_found_ff     <= 1'b0;
         a_found_ff     <= 1'b0;
         colon_found_ff <= 1'b0;
         name_any_ff    <= 1'b0;
         ps_found_ff    <= 1'b0;
      end else if (ctl.clear) begin
         s_found_ff     <= 1'b0;
         a_found_ff     <= 1'b0;
         colon_found_ff <= 1'b0;
         name_any_ff    <= 1'b0;
         ps_found_ff    <= 1'b0;
      end else if (ctl.vld) begin
         if (!s_found_ff) begin
            if (nb) begin
               s_found_ff <= 1'b1;
            end
         end else begin
            if (nb && !a_found_ff) begin
               a_found_ff <= 1'b1;
            end
            if (!colon_found_ff) begin
               if (rd_data == atrlc_pkg::CH_COLON) begin
                  colon_found_ff <= 1'b1;
               end else if (nb) begin
                  name_any_ff <= 1'b1;
               end
            end else if (nb && !ps_found_ff) begin
               ps_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int k = 0; k < atrlc_pkg::WORD_W; k++) begin
            win_ff[k] <= 8'd0;
         end
      end else if (ctl.vld) begin
         if (!s_found_ff) begin
            if (nb) begin
               s_ff      <= ctl.idx;
               e_ff      <= ctl.idx + atrlc_pkg::LEN_W'(1);
               win_ff[0] <= rd_data;
            end
         end else begin
            if (nb) begin
               e_ff <= ctl.idx + atrlc_pkg::LEN_W'(1);
            end
            if (nb && !a_found_ff) begin
               a_ff <= ctl.idx;
            end
            if (diff < atrlc_pkg::LEN_W'(atrlc_pkg::WORD_W)) begin
               win_ff[diff[atrlc_pkg::WIN_IDX_W-1:0]] <= rd_data;
            end
            if (!colon_found_ff) begin
               if (rd_data != atrlc_pkg::CH_COLON && nb) begin
                  ne_ff <= ctl.idx + atrlc_pkg::LEN_W'(1);
               end
            end else if (nb && !ps_found_ff) begin
               ps_ff <= ctl.idx;
            end
         end
      end
   end

   assign len     = e_ff - s_ff;
   assign is_ok   = (len == atrlc_pkg::LEN_W'(2)) && (win_ff[0] == atrlc_pkg::CH_O) &&
                    (win_ff[1] == atrlc_pkg::CH_K);
   assign is_err  = (len == atrlc_pkg::LEN_W'(5)) && (win_ff[0] == atrlc_pkg::CH_E) &&
                    (win_ff[1] == atrlc_pkg::CH_R) && (win_ff[2] == atrlc_pkg::CH_R) &&
                    (win_ff[3] == atrlc_pkg::CH_O) && (win_ff[4] == atrlc_pkg::CH_R);
   assign is_echo = (len >= atrlc_pkg::LEN_W'(2)) && (win_ff[0] == atrlc_pkg::CH_A) &&
                    (win_ff[1] == atrlc_pkg::CH_T);
   assign is_plus = (win_ff[0] == atrlc_pkg::CH_PLUS);

   always_comb begin
      plan         = '0;
      plan.blank   = !s_found_ff;
      plan.kind    = atrlc_pkg::KIND_INFO;
      plan.f_start = s_ff;
      plan.f_end   = e_ff;
      plan.s_empty = 1'b1;
      plan.s_start = ps_ff;
      plan.s_end   = e_ff;
      if (is_ok) begin
         plan.kind    = atrlc_pkg::KIND_OK;
         plan.f_empty = 1'b1;
      end else if (is_err) begin
         plan.kind    = atrlc_pkg::KIND_ERROR;
         plan.f_empty = 1'b1;
      end else if (is_echo) begin
         plan.kind = atrlc_pkg::KIND_ECHO;
      end else if (is_plus) begin
         plan.kind    = atrlc_pkg::KIND_PLUS;
         plan.two     = 1'b1;
         plan.f_start = a_ff;
         if (colon_found_ff) begin
            plan.f_end   = ne_ff;
            plan.f_empty = !name_any_ff;
            plan.s_empty = !ps_found_ff;
         end else begin
            plan.f_end   = e_ff;
            plan.f_empty = !a_found_ff;
         end
      end
   end

endmodule

@@ hw/rtl/at_response_line_classifier.sv @@
// Top level of the AT response line classifier: fill, scan and emit sequencer.
// Bytes are accepted one per cycle while a line is being collected; each byte other than
// CR or LF is written straight into the line store. A CR or LF on a non-empty line starts
// the line end work, during which no byte is accepted: a scan reads the n stored bytes
// through the store's one read port, a drain state passes the last read to the scanner and
// a plan state sets up the plan, then every emitted character takes a store read and then
// an output load, and every item without a character an output load alone, held while the
// response side stalls. The last item of a line waits in the output register while the next
// line is already being collected. The store needs no clearing after reset: only entries
// written in the current line are read.
module at_response_line_classifier (
   input logic        clock,
   input logic        reset,
   atrlc_req_if.sink  req_port,
   atrlc_rsp_if.source rsp_port
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_PLAN  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;
   localparam logic [2:0] ST_BARE  = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [atrlc_pkg::LEN_W-1:0] len_ff, len_in;
   logic [atrlc_pkg::LEN_W-1:0] scan_len_ff, scan_len_in;
   logic [atrlc_pkg::LEN_W-1:0] ptr_ff, ptr_in;
   logic [atrlc_pkg::LEN_W-1:0] cur_ff, cur_in;
   logic [atrlc_pkg::LEN_W-1:0] end_ff, end_in;
   logic [1:0]                  sec_ff, sec_in;
   logic                        pend_ff, pend_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [atrlc_pkg::LEN_W-1:0] rd_idx_ff, rd_idx_in;

   logic                         wr_en, rd_en;
   logic [atrlc_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]                   rd_data;
   logic                         accept, slot_free, is_full;
   logic [atrlc_pkg::LEN_W-1:0]  ptr_nxt, cur_nxt;

   logic       load, ld_has, ld_los, ld_lol;
   logic [7:0] ld_char;

   logic       rsp_valid_ff;
   logic [2:0] kind_ff;
   logic [1:0] section_ff;
   logic       has_ff, los_ff, lol_ff;
   logic [7:0] char_ff;

   atrlc_pkg::scan_ctl_type scan_ctl;
   atrlc_pkg::plan_type     plan;

   atrlc_line_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_port.in_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   atrlc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (rd_data),
      .plan    (plan)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;
   assign is_full        = (len_ff == atrlc_pkg::LEN_W'(atrlc_pkg::LINE_CAPACITY));
   assign ptr_nxt        = ptr_ff + atrlc_pkg::LEN_W'(1);
   assign cur_nxt        = cur_ff + atrlc_pkg::LEN_W'(1);
   assign wr_addr        = is_full ? '0 : len_ff[atrlc_pkg::ADDR_W-1:0];

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      scan_len_in    = scan_len_ff;
      ptr_in         = ptr_ff;
      cur_in         = cur_ff;
      end_in         = end_ff;
      sec_in         = sec_ff;
      pend_in        = pend_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = cur_ff[atrlc_pkg::ADDR_W-1:0];
      load           = 1'b0;
      ld_has         = 1'b0;
      ld_char        = 8'd0;
      ld_los         = 1'b0;
      ld_lol         = 1'b0;
      scan_ctl.clear = 1'b0;
      scan_ctl.vld   = rd_vld_ff;
      scan_ctl.idx   = rd_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (atrlc_pkg::is_term(req_port.in_byte)) begin
                  if (len_ff != '0) begin
                     scan_ctl.clear = 1'b1;
                     scan_len_in    = len_ff;
                     len_in         = '0;
                     ptr_in         = '0;
                     state_in       = ST_SCAN;
                  end
               end else begin
                  wr_en  = 1'b1;
                  len_in = is_full ? atrlc_pkg::LEN_W'(1) : len_ff + atrlc_pkg::LEN_W'(1);
               end
            end
         end
         ST_SCAN: begin
            rd_en     = 1'b1;
            rd_addr   = ptr_ff[atrlc_pkg::ADDR_W-1:0];
            rd_vld_in = 1'b1;
            rd_idx_in = ptr_ff;
            ptr_in    = ptr_nxt;
            if (ptr_nxt == scan_len_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            if (plan.blank) begin
               state_in = ST_IDLE;
            end else begin
               sec_in   = plan.two ? atrlc_pkg::SEC_NAME : atrlc_pkg::SEC_TEXT;
               pend_in  = plan.two;
               cur_in   = plan.f_start;
               end_in   = plan.f_end;
               state_in = plan.f_empty ? ST_BARE : ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) begin
               load    = 1'b1;
               ld_has  = 1'b1;
               ld_char = rd_data;
               ld_los  = (cur_nxt == end_ff);
               ld_lol  = ld_los && !pend_ff;
               if (!ld_los) begin
                  cur_in   = cur_nxt;
                  state_in = ST_READ;
               end else if (pend_ff) begin
                  pend_in  = 1'b0;
                  sec_in   = atrlc_pkg::SEC_PAYLOAD;
                  cur_in   = plan.s_start;
                  end_in   = plan.s_end;
                  state_in = plan.s_empty ? ST_BARE : ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BARE: begin
            if (slot_free) begin
               load   = 1'b1;
               ld_los = 1'b1;
               ld_lol = !pend_ff;
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  sec_in   = atrlc_pkg::SEC_PAYLOAD;
                  cur_in   = plan.s_start;
                  end_in   = plan.s_end;
                  state_in = plan.s_empty ? ST_BARE : ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_ff    <= '0;
         pend_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         pend_ff   <= pend_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_len_ff <= scan_len_in;
      ptr_ff      <= ptr_in;
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      sec_ff      <= sec_in;
      rd_idx_ff   <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= plan.kind;
         section_ff <= sec_ff;
         has_ff     <= ld_has;
         char_ff    <= ld_char;
         los_ff     <= ld_los;
         lol_ff     <= ld_lol;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.line_kind       = kind_ff;
   assign rsp_port.section         = section_ff;
   assign rsp_port.has_char        = has_ff;
   assign rsp_port.char_value      = char_ff;
   assign rsp_port.last_of_section = los_ff;
   assign rsp_port.last_of_line    = lol_ff;

endmodule

@@ hw/rtl/atrlc_checker.sv @@
// Port-level checker for the AT response line classifier, with its bind statement.
`include "assert_macros.svh"

module atrlc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_line_kind,
   input logic [1:0] rsp_section,
   input logic       rsp_has_char,
   input logic [7:0] rsp_char_value,
   input logic       rsp_last_of_section,
   input logic       rsp_last_of_line
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_line_kind) && $stable(rsp_section) && $stable(rsp_has_char) && $stable(rsp_char_value) && $stable(rsp_last_of_section) && $stable(rsp_last_of_line), "Stalled response item changed.")

   `ASSERT_IMPLIES(a_bare_item, clock, reset, rsp_valid && !rsp_has_char, rsp_last_of_section && (rsp_char_value == 8'd0), "Item without a character is not a closed empty section.")

   `ASSERT_IMPLIES(a_line_end, clock, reset, rsp_valid && rsp_last_of_line, rsp_last_of_section && (rsp_section != atrlc_pkg::SEC_NAME), "Line ended outside the final section.")

   `ASSERT_IMPLIES(a_status_kind, clock, reset, rsp_valid && ((rsp_line_kind == atrlc_pkg::KIND_OK) || (rsp_line_kind == atrlc_pkg::KIND_ERROR)), (rsp_section == atrlc_pkg::SEC_TEXT) && !rsp_has_char && rsp_last_of_line, "Status item has a bad shape.")

endmodule

bind at_response_line_classifier atrlc_checker u_atrlc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_port.valid),
   .rsp_ready           (rsp_port.ready),
   .rsp_line_kind       (rsp_port.line_kind),
   .rsp_section         (rsp_port.section),
   .rsp_has_char        (rsp_port.has_char),
   .rsp_char_value      (rsp_port.char_value),
   .rsp_last_of_section (rsp_port.last_of_section),
   .rsp_last_of_line    (rsp_port.last_of_line)
);
